>>> hdl/wnic_pkg.sv
// Shared constants for the weighted neighbor invasion cell.
`timescale 1ns / 1ps

package wnic_pkg;

    // Number of neighbors around one grid cell, in row-major order.
    localparam int NBR_COUNT = 8;

    // Width of a neighbor index.
    localparam int IDX_BITS = 3;

    // Index chosen when the roulette runs past the last cumulative weight.
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(NBR_COUNT - 1);

    // Index reported when the attempt is not accepted.
    localparam logic [IDX_BITS-1:0] IDX_NONE = '0;

endpackage

>>> hdl/weighted_neighbor_invasion_cell.sv
// Pipelined invasion probability, mean test and weighted neighbor pick for one grid cell.
//
//   channel  direction  beat contents
//   -------  ---------  ---------------------------------------------------------------
//   cfg      in         self_share, probability p in Q1.PROB_BITS (reset: one)
//   in       in         center_value, eight neighbor values, accept_draw, pick_draw
//   out      out        accepted, replace, picked_index, new_value
//
// One beat enters per cycle unless a stalled output has backed up to the first stage. The
// restoring divider resolves one quotient bit per stage for all eight neighbors in parallel.
// Reset clears the valid bits of every stage and sets self_share to one.
// Each stage holds its beat while the stage after it is full and stalled, so empty
// stages keep filling while the output waits; nothing is dropped or repeated.
`timescale 1ns / 1ps

module weighted_neighbor_invasion_cell #(
    parameter int VALUE_BITS = 32,
    parameter int PROB_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [PROB_BITS:0]             self_share,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [VALUE_BITS-1:0]          center_value,
    input  logic [VALUE_BITS-1:0]          nbr_up_left,
    input  logic [VALUE_BITS-1:0]          nbr_up,
    input  logic [VALUE_BITS-1:0]          nbr_up_right,
    input  logic [VALUE_BITS-1:0]          nbr_left,
    input  logic [VALUE_BITS-1:0]          nbr_right,
    input  logic [VALUE_BITS-1:0]          nbr_down_left,
    input  logic [VALUE_BITS-1:0]          nbr_down,
    input  logic [VALUE_BITS-1:0]          nbr_down_right,
    input  logic [PROB_BITS-1:0]           accept_draw,
    input  logic [PROB_BITS-1:0]           pick_draw,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic                           replace,
    output logic [wnic_pkg::IDX_BITS-1:0]  picked_index,
    output logic [VALUE_BITS-1:0]          new_value
);

    import wnic_pkg::*;

    // Derived widths.
    localparam int HALF_BITS = VALUE_BITS / 2;
    localparam int HIGH_BITS = VALUE_BITS - HALF_BITS;
    localparam int LO_W      = HALF_BITS + PROB_BITS + 1;
    localparam int HI_W      = HIGH_BITS + PROB_BITS + 1;
    localparam int PROD_W    = VALUE_BITS + PROB_BITS + 1;
    localparam int SUM_W     = PROD_W + 1;
    localparam int INV_W     = PROB_BITS + 1;
    localparam int TOT_W     = PROB_BITS + 4;
    localparam int TGT_W     = PROB_BITS + TOT_W;

    // Stage numbers.
    localparam int ST_MUL  = 0;
    localparam int ST_ADD  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_ACC  = PROB_BITS + 3;
    localparam int ST_TGT  = PROB_BITS + 4;
    localparam int ST_PICK = PROB_BITS + 5;
    localparam int NSTAGE  = PROB_BITS + 6;

    localparam logic [PROB_BITS:0] P_ONE = {1'b1, {PROB_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration register, saturated to one when written.
    // ------------------------------------------------------------------
    logic [PROB_BITS:0] share_reg;
    logic [PROB_BITS:0] share_next;
    logic [PROB_BITS:0] rest_share;

    assign cfg_ready  = 1'b1;
    assign share_next = (self_share > P_ONE) ? P_ONE : self_share;
    assign rest_share = P_ONE - share_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_reg <= P_ONE;
        end
        else if (cfg_valid)
        begin
            share_reg <= share_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and the ready chain.
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE:0]   en;

    always_comb
    begin
        en[NSTAGE] = out_ready;
        for (int s = NSTAGE - 1; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s + 1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < NSTAGE; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_reg[s - 1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Values and draws that travel alongside the arithmetic.
    // ------------------------------------------------------------------
    logic [VALUE_BITS-1:0] nbr_in [NBR_COUNT];
    logic [VALUE_BITS-1:0] nbr_pipe_reg    [NSTAGE-1][NBR_COUNT];
    logic [VALUE_BITS-1:0] center_pipe_reg [NSTAGE-1];
    logic [PROB_BITS-1:0]  adraw_pipe_reg  [NSTAGE-1];
    logic [PROB_BITS-1:0]  pdraw_pipe_reg  [NSTAGE-1];

    assign nbr_in[0] = nbr_up_left;
    assign nbr_in[1] = nbr_up;
    assign nbr_in[2] = nbr_up_right;
    assign nbr_in[3] = nbr_left;
    assign nbr_in[4] = nbr_right;
    assign nbr_in[5] = nbr_down_left;
    assign nbr_in[6] = nbr_down;
    assign nbr_in[7] = nbr_down_right;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            nbr_pipe_reg[0]    <= nbr_in;
            center_pipe_reg[0] <= center_value;
            adraw_pipe_reg[0]  <= accept_draw;
            pdraw_pipe_reg[0]  <= pick_draw;
        end
        for (int s = 1; s < NSTAGE - 1; s++)
        begin
            if (en[s])
            begin
                nbr_pipe_reg[s]    <= nbr_pipe_reg[s - 1];
                center_pipe_reg[s] <= center_pipe_reg[s - 1];
                adraw_pipe_reg[s]  <= adraw_pipe_reg[s - 1];
                pdraw_pipe_reg[s]  <= pdraw_pipe_reg[s - 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: half-width partial products of p*n and c*(1-p).
    // ------------------------------------------------------------------
    logic [LO_W-1:0] nlo_reg [NBR_COUNT];
    logic [HI_W-1:0] nhi_reg [NBR_COUNT];
    logic [LO_W-1:0] clo_reg;
    logic [HI_W-1:0] chi_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            for (int k = 0; k < NBR_COUNT; k++)
            begin
                nlo_reg[k] <= LO_W'(nbr_in[k][HALF_BITS-1:0]) * LO_W'(share_reg);
                nhi_reg[k] <= HI_W'(nbr_in[k][VALUE_BITS-1:HALF_BITS]) * HI_W'(share_reg);
            end
            clo_reg <= LO_W'(center_value[HALF_BITS-1:0]) * LO_W'(rest_share);
            chi_reg <= HI_W'(center_value[VALUE_BITS-1:HALF_BITS]) * HI_W'(rest_share);
        end
    end

    // ------------------------------------------------------------------
    // Recombine the partial products into full numerator and denominator terms.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] num_reg [NBR_COUNT];
    logic [PROD_W-1:0] den_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_ADD])
        begin
            for (int k = 0; k < NBR_COUNT; k++)
            begin
                num_reg[k] <= {nhi_reg[k], {HALF_BITS{1'b0}}} + PROD_W'(nlo_reg[k]);
            end
            den_reg <= {chi_reg, {HALF_BITS{1'b0}}} + PROD_W'(clo_reg);
        end
    end

    // ------------------------------------------------------------------
    // Divisor and special cases; the remainder starts at the numerator.
    // Row 0 of the divider arrays is loaded here, row j by divider step j.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]     rem_reg  [PROB_BITS+1][NBR_COUNT];
    logic [SUM_W-1:0]     dvs_reg  [PROB_BITS+1][NBR_COUNT];
    logic [PROB_BITS-1:0] quo_reg  [PROB_BITS+1][NBR_COUNT];
    logic                 full_reg [PROB_BITS+1][NBR_COUNT];
    logic                 zero_reg [PROB_BITS+1][NBR_COUNT];
    logic                 den_zero;

    assign den_zero = (den_reg == '0);

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            for (int k = 0; k < NBR_COUNT; k++)
            begin
                rem_reg[0][k]  <= SUM_W'(num_reg[k]);
                dvs_reg[0][k]  <= SUM_W'(num_reg[k]) + SUM_W'(den_reg);
                quo_reg[0][k]  <= '0;
                // A zero center term makes the ratio one, unless the numerator is zero too.
                full_reg[0][k] <= den_zero && (num_reg[k] != '0);
                zero_reg[0][k] <= den_zero && (num_reg[k] == '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: one quotient bit per stage for every neighbor.
    // ------------------------------------------------------------------
    for (genvar j = 1; j <= PROB_BITS; j++)
    begin : g_div
        logic [SUM_W:0]   trial [NBR_COUNT];
        logic [SUM_W:0]   diff  [NBR_COUNT];
        logic             fits  [NBR_COUNT];
        logic [SUM_W-1:0] rem_next [NBR_COUNT];

        always_comb
        begin
            for (int k = 0; k < NBR_COUNT; k++)
            begin
                trial[k]    = {rem_reg[j-1][k], 1'b0};
                diff[k]     = trial[k] - {1'b0, dvs_reg[j-1][k]};
                fits[k]     = (trial[k] >= {1'b0, dvs_reg[j-1][k]});
                rem_next[k] = fits[k] ? diff[k][SUM_W-1:0] : trial[k][SUM_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_SUM + j])
            begin
                for (int k = 0; k < NBR_COUNT; k++)
                begin
                    rem_reg[j][k]  <= rem_next[k];
                    dvs_reg[j][k]  <= dvs_reg[j-1][k];
                    quo_reg[j][k]  <= {quo_reg[j-1][k][PROB_BITS-2:0], fits[k]};
                    full_reg[j][k] <= full_reg[j-1][k];
                    zero_reg[j][k] <= zero_reg[j-1][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Probabilities, their total and the running sums for the roulette.
    // ------------------------------------------------------------------
    logic [INV_W-1:0] inv        [NBR_COUNT];
    logic [TOT_W-1:0] cum_next   [NBR_COUNT];
    logic [TOT_W-1:0] cum_acc_reg [NBR_COUNT-1];
    logic [TOT_W-1:0] tot_acc_reg;

    always_comb
    begin
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            priority if (zero_reg[PROB_BITS][k])
            begin
                inv[k] = '0;
            end
            else if (full_reg[PROB_BITS][k])
            begin
                inv[k] = P_ONE;
            end
            else
            begin
                inv[k] = {1'b0, quo_reg[PROB_BITS][k]};
            end
            if (k == 0)
            begin
                cum_next[k] = TOT_W'(inv[k]);
            end
            else
            begin
                cum_next[k] = cum_next[k - 1] + TOT_W'(inv[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ACC])
        begin
            for (int k = 0; k < NBR_COUNT - 1; k++)
            begin
                cum_acc_reg[k] <= cum_next[k];
            end
            tot_acc_reg <= cum_next[NBR_COUNT - 1];
        end
    end

    // ------------------------------------------------------------------
    // Mean test and roulette target pick_draw * total.
    // ------------------------------------------------------------------
    logic [TOT_W-1:0] cum_tgt_reg [NBR_COUNT-1];
    logic [TGT_W-1:0] tgt_reg;
    logic             acc_tgt_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_TGT])
        begin
            cum_tgt_reg <= cum_acc_reg;
            tgt_reg     <= TGT_W'(pdraw_pipe_reg[ST_ACC]) * TGT_W'(tot_acc_reg);
            acc_tgt_reg <= ({1'b0, adraw_pipe_reg[ST_ACC], 3'b000} <= tot_acc_reg);
        end
    end

    // ------------------------------------------------------------------
    // Neighbor pick and the result registers.
    // ------------------------------------------------------------------
    logic [IDX_BITS-1:0]   idx_next;
    logic [VALUE_BITS-1:0] pick_value;
    logic                  rep_next;

    always_comb
    begin
        idx_next = IDX_LAST;
        for (int k = NBR_COUNT - 2; k >= 0; k--)
        begin
            if ({cum_tgt_reg[k], {PROB_BITS{1'b0}}} >= tgt_reg)
            begin
                idx_next = IDX_BITS'(k);
            end
        end
        if (!acc_tgt_reg)
        begin
            idx_next = IDX_NONE;
        end
        pick_value = nbr_pipe_reg[ST_TGT][idx_next];
        rep_next   = acc_tgt_reg && (pick_value != center_pipe_reg[ST_TGT]);
    end

    logic                  accepted_reg;
    logic                  replace_reg;
    logic [IDX_BITS-1:0]   picked_index_reg;
    logic [VALUE_BITS-1:0] new_value_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PICK])
        begin
            accepted_reg     <= acc_tgt_reg;
            replace_reg      <= rep_next;
            picked_index_reg <= idx_next;
            new_value_reg    <= rep_next ? pick_value : center_pipe_reg[ST_TGT];
        end
    end

    assign accepted     = accepted_reg;
    assign replace      = replace_reg;
    assign picked_index = picked_index_reg;
    assign new_value    = new_value_reg;

endmodule
